// ===== hdl/despk_pkg.sv =====
package despk_pkg;

	// weights in Q3.16
	localparam int W_BITS = 19;
	localparam logic [W_BITS-1:0] W_EDGE = 19'd65536;
	localparam logic [W_BITS-1:0] W_CORNER = 19'd46341;
	localparam logic [W_BITS-1:0] W_TOTAL = 19'd447508;
	localparam int EDGE_SHIFT = 16;

	localparam int COORD_BITS = 12;
	localparam int CFG_INDEX_BITS = 2;
	localparam int CFG_DATA_BITS = 16;
	localparam int THR_BITS = 16;

	// register indexes
	localparam logic [CFG_INDEX_BITS-1:0] REG_DIFF_THRESHOLD = 2'd0;
	localparam logic [CFG_INDEX_BITS-1:0] REG_SHARE_THRESHOLD = 2'd1;
	localparam logic [CFG_INDEX_BITS-1:0] REG_LAST_COLUMN = 2'd2;
	localparam logic [CFG_INDEX_BITS-1:0] REG_LAST_ROW = 2'd3;

	// position of a neighbour within the 3x3 window, centre skipped
	typedef struct packed {
		logic [1:0] i;
		logic [1:0] j;
	} nb_pos_t;

	function automatic nb_pos_t nb_pos(input logic [2:0] n);
		nb_pos_t p;
		case (n)
			3'd0: p = '{i: 2'd0, j: 2'd0};
			3'd1: p = '{i: 2'd0, j: 2'd1};
			3'd2: p = '{i: 2'd0, j: 2'd2};
			3'd3: p = '{i: 2'd1, j: 2'd0};
			3'd4: p = '{i: 2'd1, j: 2'd2};
			3'd5: p = '{i: 2'd2, j: 2'd0};
			3'd6: p = '{i: 2'd2, j: 2'd1};
			default: p = '{i: 2'd2, j: 2'd2};
		endcase
		return p;
	endfunction

	function automatic logic [3:0] win_index(input logic [1:0] r, input logic [1:0] c);
		return 4'({r, 1'b0}) + 4'(r) + 4'(c);
	endfunction

endpackage

// ===== hdl/despeckle_3x3_filter_unit.sv =====
// 3x3 despeckle filter over a raster stream of RGBA pixels, each pixel carrying its own mix
// factor. Two line stores (synchronous RAMs, registered read) hold the two previous rows and a
// 3x3 window register gives each centre its eight neighbours with edge clamping. A neighbour
// counts as differing when any of R, G, B is further than diff_threshold from the centre; when
// some weight differs, the differing share beats neighbor_share_threshold and the weighted mean
// of all eight also differs, the centre is blended toward the differing neighbours' mean.
// One request is taken at a time: an input is accepted, then the window shifts and the line
// stores are written back; then each result it produces (up to four, none on row 0 unless it
// is the last row) is worked out in turn, with a DW-bit divide and a blend per channel when
// the centre is replaced, DW = CHANNEL_BITS + 19; a full output register stalls on m_tready.
// The differing mean comes from the single shared restoring divider, which gives one
// quotient bit per cycle. The full weighted mean is never divided out: its
// bounds against the centre are scaled by the total weight instead, one channel a cycle.
// A result waits in an output register; the engine goes on to the next result meanwhile.
module despeckle_3x3_filter_unit #(
	parameter int MAX_WIDTH = 4096,
	parameter int CHANNEL_BITS = 16,
	localparam int IN_BITS = ((5 * CHANNEL_BITS + 7) / 8) * 8,
	localparam int OUT_BITS = ((4 * CHANNEL_BITS + 2 * despk_pkg::COORD_BITS + 7) / 8) * 8
) (
	input logic clk,
	input logic arst_n,
	input logic s_tvalid,
	output logic s_tready,
	// in_red, in_green, in_blue, in_alpha, mix_factor
	input logic [IN_BITS-1:0] s_tdata,
	output logic m_tvalid,
	input logic m_tready,
	// out_red, out_green, out_blue, out_alpha, out_column, out_row
	output logic [OUT_BITS-1:0] m_tdata,
	output logic m_tlast,
	input logic cfg_wen,
	input logic [despk_pkg::CFG_INDEX_BITS-1:0] cfg_index,
	input logic [despk_pkg::CFG_DATA_BITS-1:0] cfg_wdata
);
	import despk_pkg::*;

	localparam int CB = CHANNEL_BITS;
	localparam int SW = 5 * CB;            // one stored sample: four channels and mix
	localparam int AW = $clog2(MAX_WIDTH);
	localparam int DW = CB + W_BITS;       // weighted sums
	localparam int AB = CB + 2;            // sum of up to four channel values
	localparam int SHARE_BITS = THR_BITS + W_BITS;
	localparam int PW = 2 * CB + 1;        // blend products
	localparam int LW = ((CB > THR_BITS) ? CB : THR_BITS) + 1;  // mean bounds
	localparam int MW = LW + W_BITS;       // mean bounds scaled by the total weight
	localparam logic [CB:0] CH_ONE = {1'b1, {CB{1'b0}}};
	localparam logic [PW-1:0] BLEND_HALF = PW'({1'b1, {(CB - 1){1'b0}}});

	typedef enum logic [11:0] {
		ST_IDLE  = 12'b000000000001,
		ST_LOAD  = 12'b000000000010,
		ST_SETUP = 12'b000000000100,
		ST_NEIGH = 12'b000000001000,
		ST_MUL   = 12'b000000010000,
		ST_MCMP  = 12'b000000100000,
		ST_TEST  = 12'b000001000000,
		ST_QDIV  = 12'b000010000000,
		ST_QWAIT = 12'b000100000000,
		ST_BLA   = 12'b001000000000,
		ST_BLB   = 12'b010000000000,
		ST_PUT   = 12'b100000000000
	} state_t;

	state_t state_q;

	// configuration
	logic [THR_BITS-1:0] diff_thr_q;
	logic [THR_BITS-1:0] share_thr_q;
	logic [COORD_BITS-1:0] last_col_q;
	logic [COORD_BITS-1:0] last_row_q;

	// raster position of the next input and of the current one
	logic [COORD_BITS-1:0] col_q;
	logic [COORD_BITS-1:0] row_q;
	logic [COORD_BITS-1:0] cur_col_q;
	logic [COORD_BITS-1:0] cur_row_q;
	logic end_col_q;
	logic end_row_q;
	logic [SW-1:0] sample_q;
	logic [AW-1:0] addr_q;
	logic [AW-1:0] rd_addr;

	// line stores: a holds the previous row, b the one before
	logic [SW-1:0] line_a [MAX_WIDTH];
	logic [SW-1:0] line_b [MAX_WIDTH];
	logic [SW-1:0] rd_a_q;
	logic [SW-1:0] rd_b_q;

	// window, index row*3+col, column 2 newest
	logic [SW-1:0] window_q [9];
	logic [3:0] win_idx;
	logic [SW-1:0] win_rd;

	// result sequencing
	logic [3:0] emit_mask_q;
	logic [1:0] emit_q;
	logic [1:0] emit_d;
	logic [1:0] row_sel_q [3];
	logic [1:0] col_sel_q [3];
	logic [1:0] sel_row_d [3];
	logic [1:0] sel_col_d [3];
	logic [3:0] emit_mask_nx;
	logic [3:0] load_mask;
	logic s_accept;

	// neighbour accumulation
	logic [SW-1:0] mid_q;
	logic [2:0] nb_q;
	nb_pos_t pos;
	logic is_side;
	logic nb_pass;
	logic [AB-1:0] sum_e_q [4];
	logic [AB-1:0] sum_c_q [4];
	logic [AB-1:0] ok_e_q [4];
	logic [AB-1:0] ok_c_q [4];
	logic [2:0] cnt_e_q;
	logic [2:0] cnt_c_q;

	// weighting, mean test, division and blend
	logic [2:0] mc_q;
	logic [DW-1:0] weighted;
	logic [DW-1:0] sum_w_q [4];
	logic [DW-1:0] ok_w_q [4];
	logic [W_BITS-1:0] fac_q;
	logic [SHARE_BITS-1:0] share_rhs_q;
	logic [1:0] ch_q;
	logic [CB-1:0] mid_ch;
	logic [LW-1:0] lim_hi;
	logic [LW-1:0] lim_lo;
	logic [MW-1:0] mean_val;
	logic mean_hit;
	logic mean_hit_q;
	logic [CB-1:0] m_q;
	logic [PW-1:0] prod_q;
	logic [PW-1:0] blend_sum;
	logic [CB-1:0] res_q [4];
	logic [CB-1:0] mix;
	logic replace;

	logic div_start;
	logic [DW-1:0] div_dividend;
	logic [W_BITS-1:0] div_divisor;
	logic div_done;
	logic [CB-1:0] div_quot;

	// output register
	logic out_valid_q;
	logic out_last_q;
	logic [OUT_BITS-1:0] out_data_q;
	logic out_free;
	logic [COORD_BITS-1:0] res_col;
	logic [COORD_BITS-1:0] res_row;

	// any of R, G, B further apart than the threshold
	function automatic logic differs(input logic [SW-1:0] a, input logic [SW-1:0] b,
			input logic [THR_BITS-1:0] thr);
		logic hit;
		logic [CB-1:0] x;
		logic [CB-1:0] y;
		logic [CB-1:0] d;
		hit = 1'b0;
		for (int k = 0; k < 3; k++) begin
			x = a[k*CB +: CB];
			y = b[k*CB +: CB];
			d = (x > y) ? x - y : y - x;
			if (32'(d) > 32'(thr)) begin
				hit = 1'b1;
			end
		end
		return hit;
	endfunction

	assign s_tready = (state_q == ST_IDLE);
	assign s_accept = s_tvalid && s_tready;

	// columns beyond the store share its last entry
	always_comb begin
		if (int'(col_q) >= MAX_WIDTH) begin
			rd_addr = AW'(MAX_WIDTH - 1);
		end else begin
			rd_addr = AW'(col_q);
		end
	end

	// configuration writes
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			diff_thr_q <= '0;
			share_thr_q <= '0;
			last_col_q <= '1;
			last_row_q <= '1;
		end else if (cfg_wen) begin
			unique case (cfg_index)
				REG_DIFF_THRESHOLD: diff_thr_q <= cfg_wdata;
				REG_SHARE_THRESHOLD: share_thr_q <= cfg_wdata;
				REG_LAST_COLUMN: last_col_q <= cfg_wdata[COORD_BITS-1:0];
				REG_LAST_ROW: last_row_q <= cfg_wdata[COORD_BITS-1:0];
			endcase
		end
	end

	// line stores: read on accept, write back during the load cycle
	always_ff @(posedge clk) begin
		if (s_accept) begin
			rd_a_q <= line_a[rd_addr];
			rd_b_q <= line_b[rd_addr];
		end
		if (state_q == ST_LOAD) begin
			line_a[addr_q] <= sample_q;
			line_b[addr_q] <= rd_a_q;
		end
	end

	// which results this input releases
	always_comb begin
		load_mask[0] = (cur_row_q != '0) && (cur_col_q != '0);
		load_mask[1] = (cur_row_q != '0) && end_col_q;
		load_mask[2] = end_row_q && (cur_col_q != '0);
		load_mask[3] = end_row_q && end_col_q;
	end

	// pick the next result and its clamped rows and columns
	always_comb begin
		if (emit_mask_q[0]) begin
			emit_d = 2'd0;
		end else if (emit_mask_q[1]) begin
			emit_d = 2'd1;
		end else if (emit_mask_q[2]) begin
			emit_d = 2'd2;
		end else begin
			emit_d = 2'd3;
		end
		if (!emit_d[1]) begin
			sel_row_d[0] = (cur_row_q == COORD_BITS'(1)) ? 2'd1 : 2'd0;
			sel_row_d[1] = 2'd1;
		end else begin
			sel_row_d[0] = (cur_row_q == '0) ? 2'd2 : 2'd1;
			sel_row_d[1] = 2'd2;
		end
		sel_row_d[2] = 2'd2;
		if (!emit_d[0]) begin
			sel_col_d[0] = (cur_col_q == COORD_BITS'(1)) ? 2'd1 : 2'd0;
			sel_col_d[1] = 2'd1;
		end else begin
			sel_col_d[0] = (cur_col_q == '0) ? 2'd2 : 2'd1;
			sel_col_d[1] = 2'd2;
		end
		sel_col_d[2] = 2'd2;
		emit_mask_nx = emit_mask_q & ~(4'b0001 << emit_q);
	end

	// single read port on the window: the centre in setup, then the neighbours one per cycle
	always_comb begin
		pos = nb_pos(nb_q);
		if (state_q == ST_SETUP) begin
			win_idx = win_index(sel_row_d[1], sel_col_d[1]);
		end else begin
			win_idx = win_index(row_sel_q[pos.i], col_sel_q[pos.j]);
		end
		win_rd = window_q[win_idx];
		is_side = (pos.i == 2'd1) || (pos.j == 2'd1);
		nb_pass = differs(win_rd, mid_q, diff_thr_q);
	end

	// corner sums times 1/sqrt2, side sums shifted
	always_comb begin
		if (mc_q[2]) begin
			weighted = DW'(ok_c_q[mc_q[1:0]]) * DW'(W_CORNER)
				+ (DW'(ok_e_q[mc_q[1:0]]) << EDGE_SHIFT);
		end else begin
			weighted = DW'(sum_c_q[mc_q[1:0]]) * DW'(W_CORNER)
				+ (DW'(sum_e_q[mc_q[1:0]]) << EDGE_SHIFT);
		end
	end

	// rounded full mean against centre +- threshold, both bounds scaled by the total weight
	always_comb begin
		mid_ch = mid_q[ch_q*CB +: CB];
		lim_hi = LW'(mid_ch) + LW'(diff_thr_q) + LW'(1);
		lim_lo = (LW'(mid_ch) > LW'(diff_thr_q)) ? LW'(mid_ch) - LW'(diff_thr_q) : '0;
		mean_val = MW'(sum_w_q[ch_q]) + MW'(W_TOTAL >> 1);
		mean_hit = (mean_val >= MW'(lim_hi) * MW'(W_TOTAL))
			|| (mean_val < MW'(lim_lo) * MW'(W_TOTAL));
	end

	always_comb begin
		mix = mid_q[4*CB +: CB];
		replace = (fac_q != '0)
			&& ((SHARE_BITS'(fac_q) << EDGE_SHIFT) > share_rhs_q)
			&& mean_hit_q;
		blend_sum = prod_q + PW'(m_q) * PW'(mix) + BLEND_HALF;
		res_col = emit_q[0] ? cur_col_q : cur_col_q - COORD_BITS'(1);
		res_row = emit_q[1] ? cur_row_q : cur_row_q - COORD_BITS'(1);
		out_free = !out_valid_q || m_tready;
	end

	// divider for the differing neighbours' mean
	always_comb begin
		div_start = (state_q == ST_QDIV);
		div_dividend = ok_w_q[ch_q] + DW'(fac_q >> 1);
		div_divisor = fac_q;
	end

	despk_div #(
		.DW(DW),
		.QW(CB)
	) u_div (
		.clk(clk),
		.arst_n(arst_n),
		.start(div_start),
		.dividend(div_dividend),
		.divisor(div_divisor),
		.done(div_done),
		.quotient(div_quot)
	);

	// sequencer and control state
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
			col_q <= '0;
			row_q <= '0;
			emit_mask_q <= '0;
			nb_q <= '0;
			mc_q <= '0;
			ch_q <= '0;
			out_valid_q <= 1'b0;
			for (int w = 0; w < 9; w++) begin
				window_q[w] <= '0;
			end
		end else begin
			if (state_q == ST_PUT && out_free) begin
				out_valid_q <= 1'b1;
			end else if (m_tready) begin
				out_valid_q <= 1'b0;
			end
			unique case (state_q)
				ST_IDLE: begin
					if (s_accept) begin
						state_q <= ST_LOAD;
					end
				end
				ST_LOAD: begin
					// shift the window left and bring in the new column
					for (int r = 0; r < 3; r++) begin
						window_q[r*3] <= window_q[r*3+1];
						window_q[r*3+1] <= window_q[r*3+2];
					end
					window_q[2] <= rd_b_q;
					window_q[5] <= rd_a_q;
					window_q[8] <= sample_q;
					if (end_col_q) begin
						col_q <= '0;
						row_q <= end_row_q ? '0 : cur_row_q + COORD_BITS'(1);
					end else begin
						col_q <= cur_col_q + COORD_BITS'(1);
					end
					emit_mask_q <= load_mask;
					state_q <= (load_mask == '0) ? ST_IDLE : ST_SETUP;
				end
				ST_SETUP: begin
					nb_q <= '0;
					state_q <= ST_NEIGH;
				end
				ST_NEIGH: begin
					nb_q <= nb_q + 3'd1;
					if (nb_q == 3'd7) begin
						mc_q <= '0;
						state_q <= ST_MUL;
					end
				end
				ST_MUL: begin
					mc_q <= mc_q + 3'd1;
					if (mc_q == 3'd7) begin
						ch_q <= '0;
						state_q <= ST_MCMP;
					end
				end
				ST_MCMP: begin
					if (ch_q == 2'd2) begin
						state_q <= ST_TEST;
					end else begin
						ch_q <= ch_q + 2'd1;
					end
				end
				ST_TEST: begin
					ch_q <= '0;
					state_q <= replace ? ST_QDIV : ST_PUT;
				end
				ST_QDIV: begin
					state_q <= ST_QWAIT;
				end
				ST_QWAIT: begin
					if (div_done) begin
						state_q <= ST_BLA;
					end
				end
				ST_BLA: begin
					state_q <= ST_BLB;
				end
				ST_BLB: begin
					if (ch_q == 2'd3) begin
						state_q <= ST_PUT;
					end else begin
						ch_q <= ch_q + 2'd1;
						state_q <= ST_QDIV;
					end
				end
				ST_PUT: begin
					if (out_free) begin
						emit_mask_q <= emit_mask_nx;
						state_q <= (emit_mask_nx == '0) ? ST_IDLE : ST_SETUP;
					end
				end
			endcase
		end
	end

	// datapath registers
	always_ff @(posedge clk) begin
		if (s_accept) begin
			sample_q <= s_tdata[SW-1:0];
			addr_q <= rd_addr;
			cur_col_q <= col_q;
			cur_row_q <= row_q;
			end_col_q <= col_q >= last_col_q;
			end_row_q <= row_q >= last_row_q;
		end
		if (state_q == ST_LOAD) begin
			share_rhs_q <= SHARE_BITS'(share_thr_q) * SHARE_BITS'(W_TOTAL);
		end
		if (state_q == ST_SETUP) begin
			emit_q <= emit_d;
			row_sel_q <= sel_row_d;
			col_sel_q <= sel_col_d;
			mid_q <= win_rd;
			cnt_e_q <= '0;
			cnt_c_q <= '0;
			mean_hit_q <= 1'b0;
			for (int k = 0; k < 4; k++) begin
				sum_e_q[k] <= '0;
				sum_c_q[k] <= '0;
				ok_e_q[k] <= '0;
				ok_c_q[k] <= '0;
			end
		end
		if (state_q == ST_NEIGH) begin
			for (int k = 0; k < 4; k++) begin
				if (is_side) begin
					sum_e_q[k] <= sum_e_q[k] + AB'(win_rd[k*CB +: CB]);
					if (nb_pass) begin
						ok_e_q[k] <= ok_e_q[k] + AB'(win_rd[k*CB +: CB]);
					end
				end else begin
					sum_c_q[k] <= sum_c_q[k] + AB'(win_rd[k*CB +: CB]);
					if (nb_pass) begin
						ok_c_q[k] <= ok_c_q[k] + AB'(win_rd[k*CB +: CB]);
					end
				end
			end
			if (nb_pass) begin
				if (is_side) begin
					cnt_e_q <= cnt_e_q + 3'd1;
				end else begin
					cnt_c_q <= cnt_c_q + 3'd1;
				end
			end
		end
		if (state_q == ST_MUL) begin
			if (mc_q[2]) begin
				ok_w_q[mc_q[1:0]] <= weighted;
			end else begin
				sum_w_q[mc_q[1:0]] <= weighted;
			end
			if (mc_q == 3'd0) begin
				fac_q <= (W_BITS'(cnt_e_q) << EDGE_SHIFT) + W_BITS'(cnt_c_q) * W_CORNER;
			end
		end
		if (state_q == ST_MCMP && mean_hit) begin
			mean_hit_q <= 1'b1;
		end
		if (state_q == ST_TEST && !replace) begin
			for (int k = 0; k < 4; k++) begin
				res_q[k] <= mid_q[k*CB +: CB];
			end
		end
		if (state_q == ST_QWAIT && div_done) begin
			m_q <= div_quot;
		end
		if (state_q == ST_BLA) begin
			prod_q <= PW'(mid_q[ch_q*CB +: CB]) * PW'(CH_ONE - (CB + 1)'(mix));
		end
		if (state_q == ST_BLB) begin
			res_q[ch_q] <= blend_sum[2*CB-1:CB];
		end
		if (state_q == ST_PUT && out_free) begin
			out_data_q <= OUT_BITS'({res_row, res_col, res_q[3], res_q[2], res_q[1], res_q[0]});
			out_last_q <= (emit_mask_nx == '0);
		end
	end

	assign m_tvalid = out_valid_q;
	assign m_tdata = out_data_q;
	assign m_tlast = out_last_q;

	a_idle_empty: assert property (@(posedge clk) disable iff (!arst_n)
		s_tready |-> (emit_mask_q == '0))
		else $error("input taken with results still pending");

	a_setup_work: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == ST_SETUP) |-> (emit_mask_q != '0))
		else $error("result setup with nothing to emit");

	a_no_zero_div: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == ST_QDIV) |-> (fac_q != '0))
		else $error("passing mean divided by zero weight");

	a_done_waited: assert property (@(posedge clk) disable iff (!arst_n)
		div_done |-> (state_q == ST_QWAIT))
		else $error("divider result arrived unexpected");

endmodule

// ===== hdl/despk_div.sv =====
module despk_div #(
	parameter int DW = 35,
	parameter int QW = 16
) (
	input logic clk,
	input logic arst_n,
	input logic start,
	input logic [DW-1:0] dividend,
	input logic [despk_pkg::W_BITS-1:0] divisor,
	output logic done,
	output logic [QW-1:0] quotient
);
	import despk_pkg::*;

	localparam int CW = $clog2(DW + 1);

	logic busy_q;
	logic done_q;
	logic [CW-1:0] cnt_q;
	logic [W_BITS-1:0] rem_q;
	logic [W_BITS-1:0] dvs_q;
	logic [DW-1:0] dvd_q;
	logic [W_BITS:0] rem_sh;
	logic ge;
	logic [W_BITS-1:0] rem_nx;

	// one quotient bit per cycle, restoring
	always_comb begin
		rem_sh = {rem_q, dvd_q[DW-1]};
		ge = rem_sh >= {1'b0, dvs_q};
		if (ge) begin
			rem_nx = W_BITS'(rem_sh - {1'b0, dvs_q});
		end else begin
			rem_nx = rem_sh[W_BITS-1:0];
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			done_q <= 1'b0;
			cnt_q <= '0;
		end else begin
			done_q <= 1'b0;
			if (start) begin
				busy_q <= 1'b1;
				cnt_q <= CW'(DW);
			end else if (busy_q) begin
				cnt_q <= cnt_q - 1'b1;
				if (cnt_q == CW'(1)) begin
					busy_q <= 1'b0;
					done_q <= 1'b1;
				end
			end
		end
	end

	always_ff @(posedge clk) begin
		if (start) begin
			dvd_q <= dividend;
			dvs_q <= divisor;
			rem_q <= '0;
		end else if (busy_q) begin
			dvd_q <= {dvd_q[DW-2:0], ge};
			rem_q <= rem_nx;
		end
	end

	assign done = done_q;
	assign quotient = dvd_q[QW-1:0];

	a_start_idle: assert property (@(posedge clk) disable iff (!arst_n)
		start |-> !busy_q)
		else $error("divider restarted while busy");

endmodule
